### design/assert_macros.svh
// Assertion macros used by the RTL of the output ownership timer.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/oot_pkg.sv
// Shared types and constants of the output ownership timer.
// No dependencies; used by oot_cfg, oot_step and output_ownership_timer_unit.
package oot_pkg;

  localparam int LATCH_W   = 8;
  localparam int HOLD_W    = 16;
  localparam int FLT_W     = 16;
  localparam int REFRESH_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOLD_W-1:0]    HOLD_TICKS_RST    = 16'd600;
  localparam logic [FLT_W-1:0]     FLT_TICKS_RST     = 16'd60;
  localparam logic [REFRESH_W-1:0] REFRESH_TICKS_RST = 8'd15;
  localparam logic [LATCH_W-1:0]   LATCH_CLEAR       = 8'h00;

  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_SET      = 1'b1;
  localparam logic OWNER_FLOAT  = 1'b0;
  localparam logic OWNER_SYSTEM = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYSTEM_HOLD  = 2'd0,
    CFG_FLOAT_RELOAD = 2'd1,
    CFG_REFRESH      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [HOLD_W-1:0]    hold_ticks;
    logic [FLT_W-1:0]     flt_ticks;
    logic [REFRESH_W-1:0] refresh_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 req_type;
    logic [LATCH_W-1:0]   out_value;
    logic                 force_req;
    logic                 modem_on;
  } item_t;

  typedef struct packed {
    logic                 owner;
    logic [LATCH_W-1:0]   latch;
    logic [HOLD_W-1:0]    hold;
    logic [FLT_W-1:0]     flt;
    logic [REFRESH_W-1:0] refresh;
  } state_t;

  typedef struct packed {
    logic [LATCH_W-1:0] latch_value;
    logic               hw_write;
    logic               owner;
    logic [HOLD_W-1:0]  hold_left;
  } result_t;

endpackage

### design/output_ownership_timer_unit.sv
// Output ownership timer: arbitrates an 8-bit output latch between the float
// switch and the remote system. Uses oot_pkg, oot_cfg, oot_step, assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transfer carries a tick
//    (req_type 0, modem_on sampled) or a set request (req_type 1, out_value
//    and force_req sampled).
//  - Result channel (res_valid/res_ready): exactly one result per input
//    transfer, in order: latch_value, hw_write strobe, owner, hold_left.
//  - Configuration: cfg_we writes cfg_data into register cfg_index at the
//    clock edge (0 system hold, 1 float reload, 2 refresh period). Write only
//    while the block is idle; unknown indexes are dropped.
//  - Pipeline: one register stage holds the accepted item; the state update
//    and result register follow once it advances, which waits while the
//    result register is full and not being read.
//  - Throughput: one item per cycle while res_ready keeps the result side
//    moving. The only loop is the state registers feeding oot_step.
//  - Stall: when res_ready is low the result register holds and the input
//    stage still takes one more item; in_ready drops only when both are full.
//  - Reset (rst, synchronous): float switch owns the outputs, latch and
//    timers cleared, refresh count 15, configuration back to 600/60/15,
//    both stages empty.
module output_ownership_timer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [oot_pkg::LATCH_W-1:0]         out_value,
  input  logic                                force_req,
  input  logic                                modem_on,
  // result channel
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [oot_pkg::LATCH_W-1:0]         latch_value,
  output logic                                hw_write,
  output logic                                owner,
  output logic [oot_pkg::HOLD_W-1:0]          hold_left,
  // configuration
  input  logic                                cfg_we,
  input  logic [oot_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [oot_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "assert_macros.svh"

  oot_pkg::cfg_t   cfg;
  oot_pkg::item_t  item;        // input register payload
  logic            item_valid;
  oot_pkg::state_t state;
  oot_pkg::state_t state_next;
  logic            strobe;
  logic            advance;

  oot_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oot_step u_step (
    .cfg    (cfg),
    .cur    (state),
    .item   (item),
    .nxt    (state_next),
    .strobe (strobe)
  );

  // Move the held item into the result register when that register is free
  // or being emptied this cycle.
  assign advance  = item_valid && (!res_valid || res_ready);
  assign in_ready = !item_valid || advance;

  // Input register: capture on transfer, drop once it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item.req_type  <= req_type;
      item.out_value <= out_value;
      item.force_req <= force_req;
      item.modem_on  <= modem_on;
    end
  end

  // Ownership state: update only as an item completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.owner   <= oot_pkg::OWNER_FLOAT;
      state.latch   <= oot_pkg::LATCH_CLEAR;
      state.hold    <= '0;
      state.flt     <= '0;
      state.refresh <= oot_pkg::REFRESH_TICKS_RST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= item_valid;
    end
    if (advance) begin
      latch_value <= state_next.latch;
      hw_write    <= strobe;
      owner       <= state_next.owner;
      hold_left   <= state_next.hold;
    end
  end

  // The float switch only takes over once the hold timer has run out, and
  // the timer never restarts without the system owning the outputs.
  `ASSERT_ALWAYS(a_float_hold_zero,
    (state.owner == oot_pkg::OWNER_FLOAT) |-> (state.hold == '0),
    "hold timer running under float ownership")

  // A held item with an empty result register must move on next edge.
  `ASSERT_CLK(a_item_advances,
    (item_valid && !res_valid) |=> res_valid,
    "held item did not reach the result register")

  // Ownership state changes only when an item completes.
  `ASSERT_CLK(a_state_stable,
    !advance |=> ($stable(state.owner) && $stable(state.latch) && $stable(state.hold)),
    "ownership state changed without a completed item")

endmodule

### design/oot_cfg.sv
// Configuration register file of the output ownership timer.
// Depends on oot_pkg for the register index codes and the cfg_t bundle.
module oot_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [oot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oot_pkg::CFG_DATA_W-1:0]   cfg_data,
  output oot_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks    <= oot_pkg::HOLD_TICKS_RST;
      cfg.flt_ticks     <= oot_pkg::FLT_TICKS_RST;
      cfg.refresh_ticks <= oot_pkg::REFRESH_TICKS_RST;
    end else if (cfg_we) begin
      case (oot_pkg::cfg_index_t'(cfg_index))
        oot_pkg::CFG_SYSTEM_HOLD:  cfg.hold_ticks    <= cfg_data;
        oot_pkg::CFG_FLOAT_RELOAD: cfg.flt_ticks     <= cfg_data;
        oot_pkg::CFG_REFRESH:      cfg.refresh_ticks <= cfg_data[oot_pkg::REFRESH_W-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

### design/oot_step.sv
// Next-state and result logic for one item of the output ownership timer.
// Depends on oot_pkg; purely combinational.
module oot_step (
  input  oot_pkg::cfg_t   cfg,
  input  oot_pkg::state_t cur,
  input  oot_pkg::item_t  item,
  output oot_pkg::state_t nxt,
  output logic            strobe
);

  always_comb begin
    logic [oot_pkg::FLT_W-1:0] flt_dec;
    nxt    = cur;
    strobe = 1'b0;
    flt_dec = '0;
    if (item.req_type == oot_pkg::REQ_SET) begin
      nxt.latch = item.out_value;
      if (item.force_req) begin
        strobe = 1'b1;
      end else if (cur.owner == oot_pkg::OWNER_SYSTEM) begin
        strobe   = 1'b1;
        nxt.hold = cfg.hold_ticks;
      end
    end else begin
      if (cur.owner == oot_pkg::OWNER_FLOAT) begin
        // nonzero latch: hand control to the system
        if (cur.latch != oot_pkg::LATCH_CLEAR) begin
          nxt.owner = oot_pkg::OWNER_SYSTEM;
          strobe    = 1'b1;
          nxt.hold  = cfg.hold_ticks;
          nxt.flt   = '0;
        end
      end else begin
        // hold expired: return control to the float switch
        if (cur.hold == '0) begin
          nxt.latch = oot_pkg::LATCH_CLEAR;
          nxt.owner = oot_pkg::OWNER_FLOAT;
          strobe    = 1'b1;
          nxt.flt   = cfg.flt_ticks;
        end
        if (item.modem_on) begin
          nxt.refresh = cfg.refresh_ticks;
        end else if (cur.refresh == '0) begin
          nxt.refresh = cfg.refresh_ticks;
          strobe      = 1'b1;
        end else begin
          nxt.refresh = cur.refresh - 1'b1;
        end
      end

      if (nxt.hold != '0) begin
        nxt.hold = nxt.hold - 1'b1;
      end

      if (nxt.flt != '0) begin
        flt_dec = nxt.flt - 1'b1;
        if (flt_dec == '0) begin
          nxt.flt   = cfg.flt_ticks;
          nxt.latch = oot_pkg::LATCH_CLEAR;
          strobe    = 1'b1;
        end else begin
          nxt.flt = flt_dec;
        end
      end
    end
  end

endmodule

### bench/oot_result_checker.sv
// Result checker for the output ownership timer: watches the input, result and
// register-write ports, predicts every result and compares it in order.
// Depends on oot_pkg for field widths, register indexes and reset values.
module oot_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            req_type,
  input  logic [oot_pkg::LATCH_W-1:0]     out_value,
  input  logic                            force_req,
  input  logic                            modem_on,
  input  logic                            res_valid,
  input  logic                            res_ready,
  input  logic [oot_pkg::LATCH_W-1:0]     latch_value,
  input  logic                            hw_write,
  input  logic                            owner,
  input  logic [oot_pkg::HOLD_W-1:0]      hold_left,
  input  logic                            cfg_we,
  input  logic [oot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oot_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import oot_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // shadow configuration
  logic [HOLD_W-1:0]    cfg_hold;
  logic [FLT_W-1:0]     cfg_float;
  logic [REFRESH_W-1:0] cfg_refresh;

  // shadow arbitration state
  logic                 cur_owner;
  logic [LATCH_W-1:0]   latch_q;
  logic [HOLD_W-1:0]    hold_ctr;
  logic [FLT_W-1:0]     float_ctr;
  logic [REFRESH_W-1:0] refresh_ctr;

  result_t pending_results[$];

  // Apply one transfer to the shadow state and return the latch report.
  function automatic result_t arbitrate_item(input item_t it);
    logic    strobe;
    result_t r;
    strobe = 1'b0;
    if (it.req_type == REQ_SET) begin
      latch_q = it.out_value;
      if (it.force_req) begin
        strobe = 1'b1;
      end else if (cur_owner == OWNER_SYSTEM) begin
        strobe   = 1'b1;
        hold_ctr = cfg_hold;
      end
    end else begin
      if (cur_owner == OWNER_FLOAT) begin
        if (latch_q != LATCH_CLEAR) begin
          cur_owner = OWNER_SYSTEM;
          strobe    = 1'b1;
          hold_ctr  = cfg_hold;
          float_ctr = '0;
        end
      end else begin
        if (hold_ctr == '0) begin
          latch_q   = LATCH_CLEAR;
          cur_owner = OWNER_FLOAT;
          strobe    = 1'b1;
          float_ctr = cfg_float;
        end
        // refresh still runs on the tick that hands control back
        if (it.modem_on) begin
          refresh_ctr = cfg_refresh;
        end else if (refresh_ctr == '0) begin
          refresh_ctr = cfg_refresh;
          strobe      = 1'b1;
        end else begin
          refresh_ctr = refresh_ctr - 1'b1;
        end
      end
      if (hold_ctr != '0) hold_ctr = hold_ctr - 1'b1;
      if (float_ctr != '0) begin
        float_ctr = float_ctr - 1'b1;
        if (float_ctr == '0) begin
          float_ctr = cfg_float;
          latch_q   = LATCH_CLEAR;
          strobe    = 1'b1;
        end
      end
    end
    r.latch_value = latch_q;
    r.hw_write    = strobe;
    r.owner       = cur_owner;
    r.hold_left   = hold_ctr;
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      cfg_hold       = HOLD_TICKS_RST;
      cfg_float      = FLT_TICKS_RST;
      cfg_refresh    = REFRESH_TICKS_RST;
      cur_owner      = OWNER_FLOAT;
      latch_q        = LATCH_CLEAR;
      hold_ctr       = '0;
      float_ctr      = '0;
      refresh_ctr    = REFRESH_TICKS_RST;
      mismatch_count = 0;
      pending_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        got.latch_value = latch_value;
        got.hw_write    = hw_write;
        got.owner       = owner;
        got.hold_left   = hold_left;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result: latch=%02h wr=%0b owner=%0b hold=%0d",
                     $realtime, got.latch_value, got.hw_write, got.owner, got.hold_left);
        end else begin
          want = pending_results.pop_front();
          if (got.latch_value !== want.latch_value || got.hw_write !== want.hw_write ||
              got.owner !== want.owner || got.hold_left !== want.hold_left) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch: expected latch=%02h wr=%0b owner=%0b hold=%0d",
                       $realtime, want.latch_value, want.hw_write, want.owner,
                       want.hold_left);
              $display("[%0t]   actual latch=%02h wr=%0b owner=%0b hold=%0d",
                       $realtime, got.latch_value, got.hw_write, got.owner,
                       got.hold_left);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        it.req_type  = req_type;
        it.out_value = out_value;
        it.force_req = force_req;
        it.modem_on  = modem_on;
        pending_results.push_back(arbitrate_item(it));
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_SYSTEM_HOLD:  cfg_hold    = cfg_data[HOLD_W-1:0];
          CFG_FLOAT_RELOAD: cfg_float   = cfg_data[FLT_W-1:0];
          CFG_REFRESH:      cfg_refresh = cfg_data[REFRESH_W-1:0];
          default: ;
        endcase
      end
    end
    results_owed = pending_results.size();
  end

endmodule

### bench/output_ownership_timer_unit_tb.sv
// Top-level bench for output_ownership_timer_unit: generates ticks and set
// requests with bursty input and stalling output, and reports the verdict.
// Depends on oot_pkg, the block itself and oot_result_checker.
module output_ownership_timer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oot_pkg::*;

  localparam realtime CLK_HALF     = 1ns;
  localparam int      RESET_CYCLES = 8;
  localparam int      PHASE_ITEMS  = 230;
  localparam int      LONG_STALL   = 60;
  localparam int      SETTLE       = 8;
  localparam int      CYCLE_LIMIT  = 400000;

  // index outside the register list; the block must drop the write
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 2'd3;

  // ready patterns of the result side
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid;
  logic                  in_ready;
  logic                  req_type;
  logic [LATCH_W-1:0]    out_value;
  logic                  force_req;
  logic                  modem_on;
  logic                  res_valid;
  logic                  res_ready;
  logic [LATCH_W-1:0]    latch_value;
  logic                  hw_write;
  logic                  owner;
  logic [HOLD_W-1:0]     hold_left;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int results_owed;
  int cycle_count    = 0;
  int stall_requests = 0;

  always #(CLK_HALF) clk = ~clk;

  output_ownership_timer_unit DUT (.*);

  oot_result_checker checker_i (.*);

  // Watchdog: a hung handshake or lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: pick a ready pattern for a random stretch of cycles, and
  // serve each long hold-off the stimulus asks for by dropping ready for a
  // LONG_STALL hold-off while the sender keeps pushing.
  initial begin
    rx_mode_e mode;
    int       seg_left;
    int       stalls_done;
    mode        = RX_STREAM;
    seg_left    = 0;
    stalls_done = 0;
    res_ready  <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_requests > stalls_done) begin
        stalls_done++;
        res_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(RX_STREAM, RX_MOSTLY));
        seg_left = $urandom_range(16, 96);
      end
      seg_left--;
      case (mode)
        RX_STREAM: res_ready <= 1'b1;
        RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: res_ready <= (seg_left % 4 == 0);
        default:   res_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic item_t make_item(input logic rt, input logic [LATCH_W-1:0] val,
                                      input logic frc, input logic mdm);
    item_t it;
    it.req_type  = rt;
    it.out_value = val;
    it.force_req = frc;
    it.modem_on  = mdm;
    return it;
  endfunction

  // Random tick or set request; unused fields stay random so they get toggled.
  function automatic item_t random_item(input int tick_pct);
    item_t it;
    it.req_type  = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_SET;
    it.force_req = ($urandom_range(0, 2) == 0);
    it.modem_on  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1:    it.out_value = LATCH_CLEAR;
      2:       it.out_value = 8'hFF;
      default: it.out_value = LATCH_W'($urandom);
    endcase
    return it;
  endfunction

  // Present one item and hold it until the transfer happens. Valid is left
  // high so the caller can chain the next item in the same step.
  task automatic offer(input item_t it);
    in_valid  <= 1'b1;
    req_type  <= it.req_type;
    out_value <= it.out_value;
    force_req <= it.force_req;
    modem_on  <= it.modem_on;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for every owed result, then let the pipeline settle.
  task automatic drain();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Program all three registers back to back; optionally poke the unused
  // index too. Upper data bits of the 8-bit register carry junk on purpose.
  task automatic write_regs(input logic [HOLD_W-1:0] hold_t, input logic [FLT_W-1:0] flt_t,
                            input logic [REFRESH_W-1:0] refr_t, input bit poke_unknown);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYSTEM_HOLD;
    cfg_data  <= hold_t;
    @(posedge clk);
    cfg_index <= CFG_FLOAT_RELOAD;
    cfg_data  <= flt_t;
    @(posedge clk);
    cfg_index <= CFG_REFRESH;
    cfg_data  <= {8'($urandom), refr_t};
    @(posedge clk);
    if (poke_unknown) begin
      cfg_index <= CFG_NO_SUCH_REG;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random bursts with random gaps; a zero gap merges bursts into longer
  // back-to-back stretches.
  task automatic run_phase(input int n_items, input int tick_pct, input bit long_stall);
    int sent;
    int burst;
    int gap;
    int k;
    sent = 0;
    if (long_stall) stall_requests++;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < n_items; k++) begin
        offer(random_item(tick_pct));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int k;
    in_valid  <= 1'b0;
    req_type  <= REQ_TICK;
    out_value <= LATCH_CLEAR;
    force_req <= 1'b0;
    modem_on  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SYSTEM_HOLD;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: short timers so hold expiry and float reload show up quickly.
    write_regs(16'd2, 16'd3, 8'd1, 1'b1);
    offer(make_item(REQ_TICK, LATCH_CLEAR, 1'b0, 1'b1));  // float, empty latch: nothing
    offer(make_item(REQ_SET, LATCH_CLEAR, 1'b0, 1'b1));   // unforced under float: no strobe
    offer(make_item(REQ_SET, LATCH_CLEAR, 1'b1, 1'b0));   // forced write of zero
    offer(make_item(REQ_SET, 8'hFF, 1'b0, 1'b0));         // latch full, still float owned
    offer(make_item(REQ_TICK, 8'hFF, 1'b1, 1'b0));        // handover; set fields ignored
    offer(make_item(REQ_SET, 8'hA5, 1'b0, 1'b0));         // system update reloads hold
    offer(make_item(REQ_SET, 8'h5A, 1'b1, 1'b1));         // modem flag ignored on sets
    repeat (5) offer(make_item(REQ_TICK, 8'h3C, 1'b0, 1'b0));  // hold countdown, then expiry
    repeat (5) offer(make_item(REQ_TICK, 8'hC3, 1'b1, 1'b1));  // float reload clears
    offer(make_item(REQ_SET, 8'h01, 1'b0, 1'b1));
    offer(make_item(REQ_TICK, LATCH_CLEAR, 1'b0, 1'b1));  // handover again
    offer(make_item(REQ_TICK, LATCH_CLEAR, 1'b0, 1'b0));
    offer(make_item(REQ_SET, 8'h80, 1'b1, 1'b0));
    repeat (3) offer(make_item(REQ_TICK, 8'h7E, 1'b1, 1'b0));
    in_valid <= 1'b0;
    drain();

    // Random phases: extremes first, then small fixed timers, then the reset
    // values, then small random timers that cycle through ownership often.
    write_regs(16'd0, 16'd0, 8'd0, 1'b0);
    run_phase(PHASE_ITEMS, 70, 1'b1);
    drain();
    write_regs(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    run_phase(PHASE_ITEMS, 50, 1'b0);
    drain();
    write_regs(16'd3, 16'd5, 8'd2, 1'b0);
    run_phase(PHASE_ITEMS, 80, 1'b0);
    drain();
    write_regs(16'd1, 16'd1, 8'd0, 1'b0);
    run_phase(PHASE_ITEMS, 75, 1'b1);
    drain();
    write_regs(HOLD_TICKS_RST, FLT_TICKS_RST, REFRESH_TICKS_RST, 1'b0);
    run_phase(PHASE_ITEMS, 85, 1'b0);
    drain();
    for (k = 0; k < 3; k++) begin
      write_regs(HOLD_W'($urandom_range(0, 6)), FLT_W'($urandom_range(0, 9)),
                 REFRESH_W'($urandom_range(0, 3)), 1'b0);
      run_phase(PHASE_ITEMS, 75, k == 1);
      drain();
    end

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/oot_pkg.sv
design/oot_cfg.sv
design/oot_step.sv
design/output_ownership_timer_unit.sv
bench/oot_result_checker.sv
bench/output_ownership_timer_unit_tb.sv
